// ===== hdl/pphdlc_pkg.sv =====
// Shared types, codes and the FCS-16 byte update for the PPP HDLC receive deframer.
package pphdlc_pkg;

  localparam logic [7:0] ADDR_BYTE = 8'hFF;
  localparam logic [7:0] CTRL_BYTE = 8'h03;
  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_XOR   = 8'h20;
  localparam logic [15:0] FCS_SEED = 16'hFFFF;
  localparam logic [15:0] FCS_POLY = 16'h8408;
  localparam logic [15:0] MTU_RESET = 16'd1500;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [2:0] PH_WAIT  = 3'd0;
  localparam logic [2:0] PH_SOF   = 3'd1;
  localparam logic [2:0] PH_ADDR  = 3'd2;
  localparam logic [2:0] PH_CTRL  = 3'd3;
  localparam logic [2:0] PH_PROTH = 3'd4;
  localparam logic [2:0] PH_DATA  = 3'd5;
  localparam logic [2:0] PH_FCSL  = 3'd6;
  localparam logic [2:0] PH_FCSH  = 3'd7;

  typedef enum logic [1:0] {
    ST_GOOD  = 2'd0,
    ST_FCS   = 2'd1,
    ST_ABORT = 2'd2,
    ST_SHORT = 2'd3
  } status_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_MARKER  = 1'b1
  } kind_e;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [15:0] protocol;
    logic [15:0] frame_length;
    logic [1:0]  status;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic logic [15:0] fcs_update(logic [15:0] fcs, logic [7:0] b);
    logic [15:0] f;
    f = fcs ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      f = f[0] ? ((f >> 1) ^ FCS_POLY) : (f >> 1);
    end
    return f;
  endfunction

  function automatic res_t mk_payload(logic [7:0] b, logic [15:0] proto);
    res_t r;
    r.kind = KIND_PAYLOAD;
    r.payload_byte = b;
    r.protocol = proto;
    r.frame_length = 16'd0;
    r.status = ST_GOOD;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic res_t mk_marker(logic [15:0] proto, logic [15:0] len, status_e st);
    res_t r;
    r.kind = KIND_MARKER;
    r.payload_byte = 8'h00;
    r.protocol = proto;
    r.frame_length = len;
    r.status = st;
    r.last = 1'b0;
    return r;
  endfunction

endpackage

// ===== hdl/pphdlc_ifs.sv =====
// Valid/ready channel interfaces for raw bytes, configuration and results.
interface pphdlc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_byte;
  modport source (output valid, output raw_byte, input ready);
  modport sink (input valid, input raw_byte, output ready);
endinterface

interface pphdlc_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] mtu_limit;
  modport source (output valid, output mtu_limit, input ready);
  modport sink (input valid, input mtu_limit, output ready);
endinterface

interface pphdlc_res_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  payload_byte;
  logic [15:0] protocol;
  logic [15:0] frame_length;
  logic [1:0]  status;
  logic        last;
  modport source (output valid, output kind, output payload_byte, output protocol,
                  output frame_length, output status, output last, input ready);
  modport sink (input valid, input kind, input payload_byte, input protocol,
                input frame_length, input status, input last, output ready);
endinterface

// ===== hdl/pphdlc_fsm.sv =====
// Deframing state machine: unescape, header check, two-byte hold, FCS-16 and end markers.
module pphdlc_fsm (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                acc_i,
  input  logic [7:0]          raw_byte_i,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_mtu_i,
  output pphdlc_pkg::push_t   push_o
);

  logic [2:0]  phase_q, phase_d;
  logic        esc_q, esc_d;
  logic [15:0] proto_q, proto_d;
  logic [15:0] fcs_q, fcs_d;
  logic [7:0]  held0_q, held0_d, held1_q, held1_d;
  logic [1:0]  hcnt_q, hcnt_d;
  logic [15:0] bcnt_q, bcnt_d;
  logic [15:0] mtu_q;
  logic [7:0]  b;
  logic        flag;
  logic [16:0] fill;
  logic [15:0] fcs_h0;
  pphdlc_pkg::push_t push;

  assign b      = esc_q ? (raw_byte_i ^ pphdlc_pkg::ESC_XOR) : raw_byte_i;
  assign flag   = !esc_q && (raw_byte_i == pphdlc_pkg::FLAG_BYTE);
  assign fill   = {1'b0, bcnt_q} + {15'd0, hcnt_q};
  assign fcs_h0 = pphdlc_pkg::fcs_update(fcs_q, held0_q);

  always_comb begin
    phase_d = phase_q;
    esc_d   = esc_q;
    proto_d = proto_q;
    fcs_d   = fcs_q;
    held0_d = held0_q;
    held1_d = held1_q;
    hcnt_d  = hcnt_q;
    bcnt_d  = bcnt_q;
    push    = '0;
    if (acc_i) begin
      if (raw_byte_i == pphdlc_pkg::ESC_BYTE) begin
        esc_d = 1'b1;
      end else begin
        esc_d = 1'b0;
        case (phase_q)
          pphdlc_pkg::PH_SOF: begin
            if (flag) begin
              phase_d = pphdlc_pkg::PH_SOF;
            end else if (b == pphdlc_pkg::ADDR_BYTE) begin
              fcs_d   = pphdlc_pkg::fcs_update(pphdlc_pkg::FCS_SEED, b);
              phase_d = pphdlc_pkg::PH_ADDR;
            end else begin
              phase_d = pphdlc_pkg::PH_WAIT;
            end
          end
          pphdlc_pkg::PH_ADDR: begin
            if (flag) begin
              phase_d = pphdlc_pkg::PH_SOF;
            end else if (b == pphdlc_pkg::CTRL_BYTE) begin
              fcs_d   = pphdlc_pkg::fcs_update(fcs_q, b);
              phase_d = pphdlc_pkg::PH_CTRL;
            end else begin
              phase_d = pphdlc_pkg::PH_WAIT;
            end
          end
          pphdlc_pkg::PH_CTRL: begin
            if (flag) begin
              phase_d = pphdlc_pkg::PH_SOF;
            end else begin
              proto_d = {b, 8'h00};
              fcs_d   = pphdlc_pkg::fcs_update(fcs_q, b);
              phase_d = pphdlc_pkg::PH_PROTH;
            end
          end
          pphdlc_pkg::PH_PROTH: begin
            if (flag) begin
              phase_d = pphdlc_pkg::PH_SOF;
            end else begin
              proto_d = {proto_q[15:8], b};
              fcs_d   = pphdlc_pkg::fcs_update(fcs_q, b);
              hcnt_d  = 2'd0;
              held0_d = 8'h00;
              held1_d = 8'h00;
              bcnt_d  = 16'd0;
              phase_d = pphdlc_pkg::PH_DATA;
            end
          end
          pphdlc_pkg::PH_DATA: begin
            if (flag) begin
              push.cnt = 2'd1;
              if (hcnt_q < 2'd2) begin
                push.r0 = pphdlc_pkg::mk_marker(proto_q, bcnt_q, pphdlc_pkg::ST_SHORT);
              end else if ({held1_q, held0_q} == ~fcs_q) begin
                push.r0 = pphdlc_pkg::mk_marker(proto_q, bcnt_q, pphdlc_pkg::ST_GOOD);
              end else begin
                push.r0 = pphdlc_pkg::mk_marker(proto_q, bcnt_q, pphdlc_pkg::ST_FCS);
              end
              phase_d = pphdlc_pkg::PH_SOF;
            end else if (fill < {1'b0, mtu_q}) begin
              case (hcnt_q)
                2'd0: begin
                  held0_d = b;
                  hcnt_d  = 2'd1;
                end
                2'd1: begin
                  held1_d = b;
                  hcnt_d  = 2'd2;
                end
                default: begin
                  push.cnt = 2'd1;
                  push.r0  = pphdlc_pkg::mk_payload(held0_q, proto_q);
                  fcs_d    = fcs_h0;
                  bcnt_d   = bcnt_q + 16'd1;
                  held0_d  = held1_q;
                  held1_d  = b;
                  hcnt_d   = 2'd2;
                end
              endcase
            end else begin
              case (hcnt_q)
                2'd0: begin
                end
                2'd1: begin
                  push.cnt = 2'd1;
                  push.r0  = pphdlc_pkg::mk_payload(held0_q, proto_q);
                  fcs_d    = fcs_h0;
                  bcnt_d   = bcnt_q + 16'd1;
                end
                default: begin
                  push.cnt = 2'd2;
                  push.r0  = pphdlc_pkg::mk_payload(held0_q, proto_q);
                  push.r1  = pphdlc_pkg::mk_payload(held1_q, proto_q);
                  fcs_d    = pphdlc_pkg::fcs_update(fcs_h0, held1_q);
                  bcnt_d   = bcnt_q + 16'd2;
                end
              endcase
              held0_d = b;
              held1_d = 8'h00;
              hcnt_d  = 2'd0;
              phase_d = pphdlc_pkg::PH_FCSL;
            end
          end
          pphdlc_pkg::PH_FCSL: begin
            if (flag) begin
              push.cnt = 2'd1;
              push.r0  = pphdlc_pkg::mk_marker(proto_q, bcnt_q, pphdlc_pkg::ST_ABORT);
              phase_d  = pphdlc_pkg::PH_SOF;
            end else if ({b, held0_q} == ~fcs_q) begin
              phase_d = pphdlc_pkg::PH_FCSH;
            end else begin
              push.cnt = 2'd1;
              push.r0  = pphdlc_pkg::mk_marker(proto_q, bcnt_q, pphdlc_pkg::ST_FCS);
              phase_d  = pphdlc_pkg::PH_WAIT;
            end
          end
          pphdlc_pkg::PH_FCSH: begin
            push.cnt = 2'd1;
            if (flag) begin
              push.r0 = pphdlc_pkg::mk_marker(proto_q, bcnt_q, pphdlc_pkg::ST_GOOD);
              phase_d = pphdlc_pkg::PH_SOF;
            end else begin
              push.r0 = pphdlc_pkg::mk_marker(proto_q, bcnt_q, pphdlc_pkg::ST_ABORT);
              phase_d = pphdlc_pkg::PH_WAIT;
            end
          end
          default: begin
            phase_d = flag ? pphdlc_pkg::PH_SOF : pphdlc_pkg::PH_WAIT;
          end
        endcase
        if (push.cnt == 2'd1) begin
          push.r0.last = 1'b1;
        end
        if (push.cnt == 2'd2) begin
          push.r1.last = 1'b1;
        end
      end
    end
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= pphdlc_pkg::PH_WAIT;
      esc_q   <= 1'b0;
      proto_q <= 16'd0;
      fcs_q   <= pphdlc_pkg::FCS_SEED;
      held0_q <= 8'h00;
      held1_q <= 8'h00;
      hcnt_q  <= 2'd0;
      bcnt_q  <= 16'd0;
      mtu_q   <= pphdlc_pkg::MTU_RESET;
    end else begin
      phase_q <= phase_d;
      esc_q   <= esc_d;
      proto_q <= proto_d;
      fcs_q   <= fcs_d;
      held0_q <= held0_d;
      held1_q <= held1_d;
      hcnt_q  <= hcnt_d;
      bcnt_q  <= bcnt_d;
      if (cfg_we_i) begin
        mtu_q <= cfg_mtu_i;
      end
    end
  end

endmodule

// ===== hdl/pphdlc_outq.sv =====
// Result queue: takes up to two results per cycle, hands out one per transfer.
module pphdlc_outq #(
  parameter int Depth = pphdlc_pkg::QUEUE_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pphdlc_pkg::push_t              push_i,
  output logic                           room_o,
  output logic                           valid_o,
  input  logic                           ready_i,
  output pphdlc_pkg::res_t               data_o,
  output logic [$clog2(Depth+1)-1:0]     level_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(Depth - 1);
  localparam logic [CW-1:0] ROOM_MAX = CW'(Depth - 2);

  pphdlc_pkg::res_t mem_q [Depth];
  logic [AW-1:0] wptr_q, wptr_d, rptr_q, rptr_d, wnext;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          pop;

  function automatic logic [AW-1:0] inc(logic [AW-1:0] p);
    return (p == LAST_IDX) ? '0 : p + AW'(1);
  endfunction

  assign wnext   = inc(wptr_q);
  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rptr_q];
  assign room_o  = (cnt_q <= ROOM_MAX);
  assign level_o = cnt_q;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    case (push_i.cnt)
      2'd1: wptr_d = wnext;
      2'd2: wptr_d = inc(wnext);
      default: wptr_d = wptr_q;
    endcase
    if (pop) begin
      rptr_d = inc(rptr_q);
    end
    cnt_d = cnt_q + CW'(push_i.cnt) - CW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wptr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wnext] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ===== hdl/ppp_hdlc_rx_deframer_core.sv =====
// Top level of the PPP HDLC receive deframer.
//
// channel  dir  payload                                                  handshake
// byte_i   in   raw_byte                                                 valid/ready
// cfg_i    in   mtu_limit                                                valid/ready
// res_o    out  kind, payload_byte, protocol, frame_length, status, last valid/ready
//
// One raw byte per cycle while the queue has room: each accepted byte is unescaped and checked
// in the same cycle, its results written to the queue; the byte-wide FCS-16 takes payload bytes on release.
// A byte yields zero, one or two results; the queue drains one per transfer.
// byte_i.ready is high while the queue has room for two results.
// cfg_i is always ready. Reset clears the frame state and sets mtu_limit to 1500.
module ppp_hdlc_rx_deframer_core #(
  parameter int QueueDepth = pphdlc_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  pphdlc_byte_if.sink         byte_i,
  pphdlc_cfg_if.sink          cfg_i,
  pphdlc_res_if.source        res_o
);

  pphdlc_pkg::push_t push;
  pphdlc_pkg::res_t  head;
  logic              room;
  logic              acc;
  logic [$clog2(QueueDepth+1)-1:0] level;

  assign byte_i.ready = room;
  assign cfg_i.ready  = 1'b1;
  assign acc          = byte_i.valid && room;

  pphdlc_fsm u_fsm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (acc),
    .raw_byte_i (byte_i.raw_byte),
    .cfg_we_i   (cfg_i.valid),
    .cfg_mtu_i  (cfg_i.mtu_limit),
    .push_o     (push)
  );

  pphdlc_outq #(
    .Depth (QueueDepth)
  ) u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (res_o.valid),
    .ready_i (res_o.ready),
    .data_o  (head),
    .level_o (level)
  );

  assign res_o.kind         = head.kind;
  assign res_o.payload_byte = head.payload_byte;
  assign res_o.protocol     = head.protocol;
  assign res_o.frame_length = head.frame_length;
  assign res_o.status       = head.status;
  assign res_o.last         = head.last;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.cnt != 2'd0) |-> acc)
    else $error("result pushed without an accepted byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && byte_i.raw_byte == pphdlc_pkg::ESC_BYTE) |-> (push.cnt == 2'd0))
    else $error("escape byte produced a result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.cnt != 2'd0) |-> (int'(level) + 2 <= QueueDepth + 1))
    else $error("queue overflow on push");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.kind == pphdlc_pkg::KIND_PAYLOAD) |->
      (res_o.frame_length == 16'd0 && res_o.status == pphdlc_pkg::ST_GOOD))
    else $error("payload result carries marker fields");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the PPP HDLC receive deframer core.
`timescale 1ns / 100ps

module tb_top;

  typedef enum int {
    FAULT_NONE,
    FAULT_FCS,
    FAULT_ADDR,
    FAULT_CTRL,
    FAULT_TAIL
  } frame_fault_e;

  localparam int NO_CUT = 1 << 20;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 16;

  class deframer_scoreboard;
    logic [15:0] mtu_limit;
    logic [2:0]  phase;
    bit          esc_pending;
    logic [15:0] proto_reg;
    logic [15:0] fcs_acc;
    logic [15:0] byte_cnt;
    logic [7:0]  held [2];
    int          held_cnt;
    pphdlc_pkg::res_t expected_q [$];
    int          errors;

    function new();
      errors = 0;
      mtu_limit = pphdlc_pkg::MTU_RESET;
      phase = pphdlc_pkg::PH_WAIT;
      esc_pending = 1'b0;
      proto_reg = '0;
      fcs_acc = pphdlc_pkg::FCS_SEED;
      byte_cnt = '0;
      held[0] = '0;
      held[1] = '0;
      held_cnt = 0;
    endfunction

    static function logic [15:0] fcs_next(logic [15:0] acc, logic [7:0] b);
      logic [15:0] f;
      f = acc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
        if (f[0]) f = (f >> 1) ^ pphdlc_pkg::FCS_POLY;
        else f = f >> 1;
      end
      return f;
    endfunction

    function void set_mtu(logic [15:0] v);
      mtu_limit = v;
    endfunction

    function void push_res(pphdlc_pkg::kind_e k, logic [7:0] b, logic [15:0] len,
                           pphdlc_pkg::status_e st);
      pphdlc_pkg::res_t r;
      r.kind = k;
      r.payload_byte = b;
      r.protocol = proto_reg;
      r.frame_length = len;
      r.status = st;
      r.last = 1'b0;
      expected_q.push_back(r);
    endfunction

    function void emit_held();
      push_res(pphdlc_pkg::KIND_PAYLOAD, held[0], 16'd0, pphdlc_pkg::ST_GOOD);
      fcs_acc = fcs_next(fcs_acc, held[0]);
      byte_cnt = byte_cnt + 16'd1;
      held[0] = held[1];
      held[1] = '0;
      held_cnt--;
    endfunction

    function void note_byte(logic [7:0] raw);
      logic [7:0]  b;
      bit          is_flag;
      int          prev_n;
      logic [15:0] rx;
      if (raw == pphdlc_pkg::ESC_BYTE) begin
        esc_pending = 1'b1;
        return;
      end
      b = raw;
      is_flag = 1'b0;
      if (esc_pending) b = raw ^ pphdlc_pkg::ESC_XOR;
      else is_flag = (raw == pphdlc_pkg::FLAG_BYTE);
      esc_pending = 1'b0;
      prev_n = expected_q.size();
      case (phase)
        pphdlc_pkg::PH_SOF: begin
          if (is_flag) phase = pphdlc_pkg::PH_SOF;
          else if (b == pphdlc_pkg::ADDR_BYTE) begin
            fcs_acc = fcs_next(pphdlc_pkg::FCS_SEED, b);
            phase = pphdlc_pkg::PH_ADDR;
          end else phase = pphdlc_pkg::PH_WAIT;
        end
        pphdlc_pkg::PH_ADDR: begin
          if (is_flag) phase = pphdlc_pkg::PH_SOF;
          else if (b == pphdlc_pkg::CTRL_BYTE) begin
            fcs_acc = fcs_next(fcs_acc, b);
            phase = pphdlc_pkg::PH_CTRL;
          end else phase = pphdlc_pkg::PH_WAIT;
        end
        pphdlc_pkg::PH_CTRL: begin
          if (is_flag) phase = pphdlc_pkg::PH_SOF;
          else begin
            proto_reg = {b, 8'h00};
            fcs_acc = fcs_next(fcs_acc, b);
            phase = pphdlc_pkg::PH_PROTH;
          end
        end
        pphdlc_pkg::PH_PROTH: begin
          if (is_flag) phase = pphdlc_pkg::PH_SOF;
          else begin
            proto_reg[7:0] = b;
            fcs_acc = fcs_next(fcs_acc, b);
            held_cnt = 0;
            held[0] = '0;
            held[1] = '0;
            byte_cnt = '0;
            phase = pphdlc_pkg::PH_DATA;
          end
        end
        pphdlc_pkg::PH_DATA: begin
          if (is_flag) begin
            if (held_cnt < 2) begin
              push_res(pphdlc_pkg::KIND_MARKER, 8'h00, byte_cnt, pphdlc_pkg::ST_SHORT);
            end else begin
              rx = {held[1], held[0]};
              if (rx == ~fcs_acc) begin
                push_res(pphdlc_pkg::KIND_MARKER, 8'h00, byte_cnt, pphdlc_pkg::ST_GOOD);
              end else begin
                push_res(pphdlc_pkg::KIND_MARKER, 8'h00, byte_cnt, pphdlc_pkg::ST_FCS);
              end
            end
            phase = pphdlc_pkg::PH_SOF;
          end else if (int'(byte_cnt) + held_cnt < int'(mtu_limit)) begin
            if (held_cnt >= 2) emit_held();
            held[held_cnt & 1] = b;
            held_cnt++;
          end else begin
            while (held_cnt > 0) emit_held();
            held[0] = b;
            held[1] = '0;
            phase = pphdlc_pkg::PH_FCSL;
          end
        end
        pphdlc_pkg::PH_FCSL: begin
          if (is_flag) begin
            push_res(pphdlc_pkg::KIND_MARKER, 8'h00, byte_cnt, pphdlc_pkg::ST_ABORT);
            phase = pphdlc_pkg::PH_SOF;
          end else begin
            rx = {b, held[0]};
            if (rx == ~fcs_acc) phase = pphdlc_pkg::PH_FCSH;
            else begin
              push_res(pphdlc_pkg::KIND_MARKER, 8'h00, byte_cnt, pphdlc_pkg::ST_FCS);
              phase = pphdlc_pkg::PH_WAIT;
            end
          end
        end
        pphdlc_pkg::PH_FCSH: begin
          if (is_flag) begin
            push_res(pphdlc_pkg::KIND_MARKER, 8'h00, byte_cnt, pphdlc_pkg::ST_GOOD);
            phase = pphdlc_pkg::PH_SOF;
          end else begin
            push_res(pphdlc_pkg::KIND_MARKER, 8'h00, byte_cnt, pphdlc_pkg::ST_ABORT);
            phase = pphdlc_pkg::PH_WAIT;
          end
        end
        default: phase = is_flag ? pphdlc_pkg::PH_SOF : pphdlc_pkg::PH_WAIT;
      endcase
      if (expected_q.size() > prev_n) expected_q[expected_q.size() - 1].last = 1'b1;
    endfunction

    function void check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
      if (exp_v !== got_v) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(pphdlc_pkg::res_t got);
      pphdlc_pkg::res_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      check_field("kind", 16'(exp_r.kind), 16'(got.kind));
      check_field("payload_byte", 16'(exp_r.payload_byte), 16'(got.payload_byte));
      check_field("protocol", exp_r.protocol, got.protocol);
      check_field("frame_length", exp_r.frame_length, got.frame_length);
      check_field("status", 16'(exp_r.status), 16'(got.status));
      check_field("last", 16'(exp_r.last), 16'(got.last));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  pphdlc_byte_if byte_if ();
  pphdlc_cfg_if  cfg_if ();
  pphdlc_res_if  res_if ();

  ppp_hdlc_rx_deframer_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .byte_i (byte_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  deframer_scoreboard sb = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int hold_served = 0;
  int hold_left = 0;
  int items_sent = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #8_000_000;
    $display("tb_top failed");
    $finish;
  end

  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        res_if.ready = 1'b0;
        hold_left--;
      end else if (hold_req != hold_served) begin
        hold_served++;
        hold_left = HOLD_CYCLES - 1;
        res_if.ready = 1'b0;
      end else begin
        res_if.ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    pphdlc_pkg::res_t got;
    if (rst_n && res_if.valid && res_if.ready) begin
      got.kind = res_if.kind;
      got.payload_byte = res_if.payload_byte;
      got.protocol = res_if.protocol;
      got.frame_length = res_if.frame_length;
      got.status = res_if.status;
      got.last = res_if.last;
      sb.check_result(got);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_if.valid = 1'b0;
      @(negedge clk);
    end
    byte_if.valid = 1'b1;
    byte_if.raw_byte = b;
    do @(posedge clk); while (!byte_if.ready);
    sb.note_byte(b);
  endtask

  task automatic send_frame(input logic [15:0] proto, input int plen,
                            input frame_fault_e fault, input int cut);
    logic [7:0]  body [$];
    logic [15:0] crc;
    logic [7:0]  c;
    body = {pphdlc_pkg::ADDR_BYTE, pphdlc_pkg::CTRL_BYTE, proto[15:8], proto[7:0]};
    for (int i = 0; i < plen; i++) body.push_back(8'($urandom_range(255)));
    crc = pphdlc_pkg::FCS_SEED;
    foreach (body[i]) crc = deframer_scoreboard::fcs_next(crc, body[i]);
    crc = ~crc;
    if (fault == FAULT_FCS) crc ^= 16'(1 << $urandom_range(15));
    body.push_back(crc[7:0]);
    body.push_back(crc[15:8]);
    if (fault == FAULT_ADDR) body[0] = 8'($urandom_range(254));
    if (fault == FAULT_CTRL) begin
      c = 8'($urandom_range(255));
      body[1] = (c == pphdlc_pkg::CTRL_BYTE) ? 8'h04 : c;
    end
    if (fault == FAULT_TAIL) body.push_back(8'($urandom_range(255)));
    while (body.size() > cut) void'(body.pop_back());
    send_byte(pphdlc_pkg::FLAG_BYTE);
    foreach (body[i]) begin
      if (body[i] == pphdlc_pkg::FLAG_BYTE || body[i] == pphdlc_pkg::ESC_BYTE ||
          $urandom_range(15) == 0) begin
        send_byte(pphdlc_pkg::ESC_BYTE);
        send_byte(body[i] ^ pphdlc_pkg::ESC_XOR);
      end else begin
        send_byte(body[i]);
      end
    end
    items_sent += body.size() + 1;
  endtask

  task automatic send_seq(input logic [7:0] seq [$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic drain_and_configure(input bit do_write, input logic [15:0] mtu);
    @(negedge clk);
    byte_if.valid = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (do_write) begin
      @(negedge clk);
      cfg_if.valid = 1'b1;
      cfg_if.mtu_limit = mtu;
      do @(posedge clk); while (!cfg_if.ready);
      sb.set_mtu(mtu);
      @(negedge clk);
      cfg_if.valid = 1'b0;
    end
  endtask

  task automatic run_random(input int target);
    int r;
    int plen;
    logic [15:0] proto;
    while (items_sent < target) begin
      r = $urandom_range(99);
      plen = ($urandom_range(19) == 0) ? $urandom_range(25, 200) : $urandom_range(0, 24);
      proto = 16'($urandom_range(16'hFFFF));
      if (r < 62) send_frame(proto, plen, FAULT_NONE, NO_CUT);
      else if (r < 74) send_frame(proto, plen, FAULT_FCS, NO_CUT);
      else if (r < 80) send_frame(proto, plen, FAULT_TAIL, NO_CUT);
      else if (r < 86) send_frame(proto, plen, FAULT_NONE, $urandom_range(0, plen + 5));
      else if (r < 90) send_frame(proto, plen, FAULT_ADDR, NO_CUT);
      else if (r < 94) send_frame(proto, plen, FAULT_CTRL, NO_CUT);
      else repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(255)));
    end
    send_byte(pphdlc_pkg::FLAG_BYTE);
  endtask

  initial begin
    rst_n = 1'b0;
    byte_if.valid = 1'b0;
    byte_if.raw_byte = '0;
    cfg_if.valid = 1'b0;
    cfg_if.mtu_limit = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 36;
    recv_idle_pct = 63;
    send_seq({8'h00, pphdlc_pkg::FLAG_BYTE, pphdlc_pkg::FLAG_BYTE});
    send_seq({pphdlc_pkg::ADDR_BYTE, pphdlc_pkg::CTRL_BYTE, 8'hC0, pphdlc_pkg::FLAG_BYTE});
    send_seq({8'h12, pphdlc_pkg::FLAG_BYTE, pphdlc_pkg::ADDR_BYTE, 8'h04,
              pphdlc_pkg::FLAG_BYTE});
    send_seq({pphdlc_pkg::ADDR_BYTE, pphdlc_pkg::CTRL_BYTE, 8'h00, 8'h21, 8'hAB,
              pphdlc_pkg::FLAG_BYTE});
    send_seq({pphdlc_pkg::ADDR_BYTE, pphdlc_pkg::CTRL_BYTE, 8'h80, 8'h21,
              pphdlc_pkg::ESC_BYTE, pphdlc_pkg::ESC_BYTE, 8'h5E,
              pphdlc_pkg::ESC_BYTE, pphdlc_pkg::FLAG_BYTE, pphdlc_pkg::FLAG_BYTE});

    drain_and_configure(1'b1, 16'($urandom_range(577, 65534)));
    items_sent = 0;
    run_random(120);

    send_idle_pct = 63;
    recv_idle_pct = 36;
    drain_and_configure(1'b1, 16'hFFFF);
    items_sent = 0;
    run_random(120);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain_and_configure(1'b1, 16'd576);
    hold_req++;
    send_frame(16'($urandom_range(16'hFFFF)), 576, FAULT_NONE, NO_CUT);
    items_sent = 0;
    run_random(70);

    drain_and_configure(1'b0, '0);
    if (sb.expected_q.size() != 0) begin
      $display("%0t: %0d results missing, expected %h, actual none", $time,
               sb.expected_q.size(), sb.expected_q[0]);
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
